/* design/wmsbf_pkg.sv */
// Package for the windowed mean / sigma box filter.
// Holds table geometry, entry layout, channel payload types and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wmsbf_pkg;

  localparam int MAX_X  = 64;
  localparam int MAX_Y  = 64;
  localparam int MAX_Z  = 8;
  localparam int X_W    = 6;
  localparam int Y_W    = 6;
  localparam int Z_W    = 3;
  localparam int ADDR_W = X_W + Y_W + Z_W;
  localparam int DEPTH  = MAX_X * MAX_Y * MAX_Z;

  // One table entry: running sum, running sum of squares, running count.
  localparam int SUM_W   = 32;
  localparam int SQ_W    = 48;
  localparam int CNT_W   = 16;
  localparam int ENTRY_W = SUM_W + SQ_W + CNT_W;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    CFG_SIZE_X = 3'd0,
    CFG_SIZE_Y = 3'd1,
    CFG_SIZE_Z = 3'd2,
    CFG_HALF_X = 3'd3,
    CFG_HALF_Y = 3'd4,
    CFG_HALF_Z = 3'd5,
    CFG_IGNORE = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic               func;
    logic signed [15:0] sample;
    logic [5:0]         qx;
    logic [5:0]         qy;
    logic [2:0]         qz;
  } in_t;

  typedef struct packed {
    logic [15:0]        count;
    logic signed [23:0] mean;
    logic [23:0]        sigma;
    logic               mean_valid;
    logic               sigma_valid;
  } out_t;

endpackage
`default_nettype wire

/* design/windowed_mean_sigma_box_filter_core.sv */
// 3D box filter core: summed-area tables in one on-chip memory, query sequencer,
// shared radix-2 divider and digit-by-digit square root.
// Depends on wmsbf_pkg.
//
// Usage. Samples arrive on the in_ channel with func = load, in raster order,
// x fastest; each one extends the sum, square-sum and count tables. A transaction
// with func = query names a voxel and produces one out_ transaction holding the
// count, Q16.8 mean and Q16.8 sample sigma over the clipped window. Loads
// produce nothing on the out_ channel.
// Timing. A load makes 7 reads of the single memory port at one per cycle, drains
// the read pipe and writes the entry. The first load after a size register write
// first converts the linear load position back into coordinates through the divider.
// A query makes 8 corner reads, passes the multiply states, then runs two 48-step
// divisions (mean, then variance) and a 24-step square root. An empty window goes
// straight to output, one sample skips the variance, an overflow skips the root.
// One transaction is in work at a time; in_ready is high whenever the core is idle.
// Reset sets the control and configuration registers to their defaults and clears the
// load position; table contents are left as they are and must be loaded before being
// queried. A stalled receiver only holds the output register; the core keeps accepting
// loads, and a second query result waits until the first one is taken.
`timescale 1ns / 1ps
`default_nettype none
module windowed_mean_sigma_box_filter_core import wmsbf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_LDV1 = 14'b00000000000010,
    ST_LDV2 = 14'b00000000000100,
    ST_LDRD = 14'b00000000001000,
    ST_LDWR = 14'b00000000010000,
    ST_QRD  = 14'b00000000100000,
    ST_PREP = 14'b00000001000000,
    ST_MUL1 = 14'b00000010000000,
    ST_MUL2 = 14'b00000100000000,
    ST_MUL3 = 14'b00001000000000,
    ST_DIVM = 14'b00010000000000,
    ST_DIVV = 14'b00100000000000,
    ST_SQRT = 14'b01000000000000,
    ST_OUT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [6:0]         size_x_r, size_y_r;
  logic [3:0]         size_z_r;
  logic [5:0]         half_x_r, half_y_r;
  logic [2:0]         half_z_r;
  logic signed [15:0] ignore_r;

  logic [6:0] sx_e, sy_e, sxm1, sym1;
  logic [3:0] sz_e, szm1;

  assign sx_e = (size_x_r == 7'd0) ? 7'd1 : ((size_x_r > 7'(MAX_X)) ? 7'(MAX_X) : size_x_r);
  assign sy_e = (size_y_r == 7'd0) ? 7'd1 : ((size_y_r > 7'(MAX_Y)) ? 7'(MAX_Y) : size_y_r);
  assign sz_e = (size_z_r == 4'd0) ? 4'd1 : ((size_z_r > 4'(MAX_Z)) ? 4'(MAX_Z) : size_z_r);
  assign sxm1 = sx_e - 7'd1;
  assign sym1 = sy_e - 7'd1;
  assign szm1 = sz_e - 4'd1;

  // Load position, kept both linear and as coordinates.
  logic [ADDR_W-1:0] ld_p_r;
  logic [X_W-1:0]    ld_x_r;
  logic [Y_W-1:0]    ld_y_r;
  logic [Z_W-1:0]    ld_z_r;
  logic              stale_r;

  logic in_accept;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  // Table memory and read pipe.
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [3:0]         c_r;
  logic               pend_r, sub_r;

  // Query window corners.
  logic [X_W-1:0] hi_x_r, lo_x_r;
  logic [Y_W-1:0] hi_y_r, lo_y_r;
  logic [Z_W-1:0] hi_z_r, lo_z_r;
  logic [2:0]     lo_ok_r;

  // Accumulators.
  logic signed [33:0] acc_s_r;
  logic signed [49:0] acc_q_r;
  logic signed [17:0] acc_n_r;

  // Post-processing.
  logic [30:0] as_r;
  logic [47:0] aq_r;
  logic [15:0] n16_r, nm1_r;
  logic        neg_r;
  logic [39:0] p0_r, p1_r;
  logic [61:0] sq_r;
  logic [29:0] d_r;
  logic [63:0] na_r;
  logic [79:0] vd_r;
  logic [23:0] mean_r, sigma_r;
  logic [15:0] cnt_o_r;
  logic        mv_r, sv_r;

  // Divider.
  logic        dv_start;
  logic [79:0] dv_start_dvd;
  logic [29:0] dv_start_den;
  logic [29:0] dv_rem_r, dv_den_r;
  logic [47:0] dv_dvd_r, dv_q_r;
  logic [5:0]  dv_cnt_r;
  logic        dv_ovf_r;

  // Square root.
  logic        sq_start;
  logic [47:0] sq_v_r;
  logic [26:0] sq_rem_r;
  logic [23:0] sq_root_r;
  logic [4:0]  sq_cnt_r;

  out_t out_data_r;
  logic out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- Query coordinate clipping ----------------
  logic [X_W-1:0] qx_c, qx_hi, qx_lo;
  logic [Y_W-1:0] qy_c, qy_hi, qy_lo;
  logic [Z_W-1:0] qz_c, qz_hi, qz_lo;
  logic [6:0]     qx_sum, qy_sum;
  logic [3:0]     qz_sum;

  always_comb begin
    qx_c   = ({1'b0, in_data.qx} > sxm1) ? sxm1[X_W-1:0] : in_data.qx;
    qy_c   = ({1'b0, in_data.qy} > sym1) ? sym1[Y_W-1:0] : in_data.qy;
    qz_c   = ({1'b0, in_data.qz} > szm1) ? szm1[Z_W-1:0] : in_data.qz;
    qx_sum = {1'b0, qx_c} + {1'b0, half_x_r};
    qy_sum = {1'b0, qy_c} + {1'b0, half_y_r};
    qz_sum = {1'b0, qz_c} + {1'b0, half_z_r};
    qx_hi  = (qx_sum > sxm1) ? sxm1[X_W-1:0] : qx_sum[X_W-1:0];
    qy_hi  = (qy_sum > sym1) ? sym1[Y_W-1:0] : qy_sum[Y_W-1:0];
    qz_hi  = (qz_sum > szm1) ? szm1[Z_W-1:0] : qz_sum[Z_W-1:0];
    qx_lo  = qx_c - half_x_r - 6'd1;
    qy_lo  = qy_c - half_y_r - 6'd1;
    qz_lo  = qz_c - half_z_r - 3'd1;
  end

  // ---------------- Read address generation ----------------
  logic           rd_issue, rd_ok, rd_sub, is_load_rd;
  logic [X_W-1:0] rx;
  logic [Y_W-1:0] ry;
  logic [Z_W-1:0] rz;

  always_comb begin
    is_load_rd = (state_r == ST_LDRD);
    rd_issue   = ((state_r == ST_LDRD) || (state_r == ST_QRD)) && !c_r[3];
    if (is_load_rd) begin
      // Neighbors behind the current voxel; odd-weight corners add.
      rx     = ld_x_r - X_W'(c_r[0]);
      ry     = ld_y_r - Y_W'(c_r[1]);
      rz     = ld_z_r - Z_W'(c_r[2]);
      rd_ok  = !(c_r[0] && (ld_x_r == '0)) && !(c_r[1] && (ld_y_r == '0)) &&
               !(c_r[2] && (ld_z_r == '0));
      rd_sub = !(^c_r[2:0]);
    end else begin
      rx     = c_r[0] ? lo_x_r : hi_x_r;
      ry     = c_r[1] ? lo_y_r : hi_y_r;
      rz     = c_r[2] ? lo_z_r : hi_z_r;
      rd_ok  = !(c_r[0] && !lo_ok_r[0]) && !(c_r[1] && !lo_ok_r[1]) &&
               !(c_r[2] && !lo_ok_r[2]);
      rd_sub = ^c_r[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LDWR) begin
      mem[{ld_z_r, ld_y_r, ld_x_r}] <= {acc_s_r[SUM_W-1:0], acc_q_r[SQ_W-1:0],
                                        acc_n_r[CNT_W-1:0]};
    end
    if (rd_issue) begin
      rd_data_r <= mem[{rz, ry, rx}];
    end
  end

  // ---------------- Sequencer ----------------
  always_comb begin
    state_nxt    = state_r;
    dv_start     = 1'b0;
    dv_start_dvd = '0;
    dv_start_den = '0;
    sq_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.func == FUNC_QUERY) begin
            state_nxt = ST_QRD;
          end else if (stale_r) begin
            state_nxt    = ST_LDV1;
            dv_start     = 1'b1;
            dv_start_dvd = {65'd0, ld_p_r};
            dv_start_den = {23'd0, sx_e};
          end else begin
            state_nxt = ST_LDRD;
          end
        end
      end
      ST_LDV1: begin
        if (dv_cnt_r == 6'd0) begin
          state_nxt    = ST_LDV2;
          dv_start     = 1'b1;
          dv_start_dvd = {32'd0, dv_q_r};
          dv_start_den = {23'd0, sy_e};
        end
      end
      ST_LDV2: begin
        if (dv_cnt_r == 6'd0) begin
          state_nxt = ST_LDRD;
        end
      end
      ST_LDRD: begin
        if (c_r[3]) begin
          state_nxt = ST_LDWR;
        end
      end
      ST_LDWR: state_nxt = ST_IDLE;
      ST_QRD: begin
        if (c_r[3]) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: state_nxt = (acc_n_r > 18'sd0) ? ST_MUL1 : ST_OUT;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: begin
        state_nxt    = ST_DIVM;
        dv_start     = 1'b1;
        dv_start_dvd = {41'd0, as_r, 8'd0};
        dv_start_den = {14'd0, n16_r};
      end
      ST_DIVM: begin
        if (dv_cnt_r == 6'd0) begin
          if (sv_r) begin
            state_nxt    = ST_DIVV;
            dv_start     = 1'b1;
            dv_start_dvd = vd_r;
            dv_start_den = d_r;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DIVV: begin
        if (dv_cnt_r == 6'd0) begin
          if (dv_ovf_r) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_SQRT;
            sq_start  = 1'b1;
          end
        end
      end
      ST_SQRT: begin
        if (sq_cnt_r == 5'd0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Load position advance in raster order.
  logic x_last, y_last, z_last;
  assign x_last = ({1'b0, ld_x_r} + 7'd1) >= sx_e;
  assign y_last = ({1'b0, ld_y_r} + 7'd1) >= sy_e;
  assign z_last = ({1'b0, ld_z_r} + 4'd1) >= sz_e;

  // ---------------- Control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_x_r    <= 7'(MAX_X);
      size_y_r    <= 7'(MAX_Y);
      size_z_r    <= 4'(MAX_Z);
      half_x_r    <= 6'd1;
      half_y_r    <= 6'd1;
      half_z_r    <= 3'd0;
      ignore_r    <= 16'sh8000;
      ld_p_r      <= '0;
      ld_x_r      <= '0;
      ld_y_r      <= '0;
      ld_z_r      <= '0;
      stale_r     <= 1'b0;
      c_r         <= '0;
      pend_r      <= 1'b0;
      dv_cnt_r    <= '0;
      sq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SIZE_X: size_x_r <= cfg_wdata[6:0];
          CFG_SIZE_Y: size_y_r <= cfg_wdata[6:0];
          CFG_SIZE_Z: size_z_r <= cfg_wdata[3:0];
          CFG_HALF_X: half_x_r <= cfg_wdata[5:0];
          CFG_HALF_Y: half_y_r <= cfg_wdata[5:0];
          CFG_HALF_Z: half_z_r <= cfg_wdata[2:0];
          CFG_IGNORE: ignore_r <= cfg_wdata;
          default: ;
        endcase
      end

      // A size change invalidates the coordinate form of the load position.
      if (cfg_wr_en && ((cfg_idx_t'(cfg_index) == CFG_SIZE_X) ||
                        (cfg_idx_t'(cfg_index) == CFG_SIZE_Y) ||
                        (cfg_idx_t'(cfg_index) == CFG_SIZE_Z))) begin
        stale_r <= 1'b1;
      end else if ((state_r == ST_LDV2) && (dv_cnt_r == 6'd0)) begin
        stale_r <= 1'b0;
      end

      if ((state_r == ST_LDV1) && (dv_cnt_r == 6'd0)) begin
        ld_x_r <= dv_rem_r[X_W-1:0];
      end
      if ((state_r == ST_LDV2) && (dv_cnt_r == 6'd0)) begin
        if (dv_q_r >= {44'd0, sz_e}) begin
          ld_p_r <= '0;
          ld_x_r <= '0;
          ld_y_r <= '0;
          ld_z_r <= '0;
        end else begin
          ld_y_r <= dv_rem_r[Y_W-1:0];
          ld_z_r <= dv_q_r[Z_W-1:0];
        end
      end
      if (state_r == ST_LDWR) begin
        if (!x_last) begin
          ld_x_r <= ld_x_r + 6'd1;
          ld_p_r <= ld_p_r + 15'd1;
        end else if (!y_last) begin
          ld_x_r <= '0;
          ld_y_r <= ld_y_r + 6'd1;
          ld_p_r <= ld_p_r + 15'd1;
        end else if (!z_last) begin
          ld_x_r <= '0;
          ld_y_r <= '0;
          ld_z_r <= ld_z_r + 3'd1;
          ld_p_r <= ld_p_r + 15'd1;
        end else begin
          ld_x_r <= '0;
          ld_y_r <= '0;
          ld_z_r <= '0;
          ld_p_r <= '0;
        end
      end

      if (in_accept) begin
        c_r <= (in_data.func == FUNC_QUERY) ? 4'd0 : 4'd1;
      end else if (rd_issue) begin
        c_r <= c_r + 4'd1;
      end
      pend_r <= rd_issue && rd_ok;

      if (dv_start) begin
        dv_cnt_r <= 6'd48;
      end else if (dv_cnt_r != 6'd0) begin
        dv_cnt_r <= dv_cnt_r - 6'd1;
      end

      if (sq_start) begin
        sq_cnt_r <= 5'd24;
      end else if (sq_cnt_r != 5'd0) begin
        sq_cnt_r <= sq_cnt_r - 5'd1;
      end

      if ((state_r == ST_OUT) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- Datapath ----------------
  logic signed [31:0] samp_sq;
  logic [30:0]        dv_t;
  logic [26:0]        sq_r2, sq_tr;
  logic [63:0]        sum_a;
  logic [31:0]        d_prod;

  assign samp_sq = in_data.sample * in_data.sample;
  assign dv_t    = {dv_rem_r, dv_dvd_r[47]};
  assign sq_r2   = {sq_rem_r[24:0], sq_v_r[47:46]};
  assign sq_tr   = {1'b0, sq_root_r, 2'b01};
  assign sum_a   = {24'd0, p0_r} + {p1_r, 24'd0};
  assign d_prod  = {16'd0, n16_r} * {16'd0, nm1_r};

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if ((in_data.func == FUNC_LOAD) && (in_data.sample != ignore_r)) begin
        acc_s_r <= {{18{in_data.sample[15]}}, in_data.sample};
        acc_q_r <= {{18{samp_sq[31]}}, samp_sq};
        acc_n_r <= 18'sd1;
      end else begin
        acc_s_r <= '0;
        acc_q_r <= '0;
        acc_n_r <= '0;
      end
      hi_x_r  <= qx_hi;
      hi_y_r  <= qy_hi;
      hi_z_r  <= qz_hi;
      lo_x_r  <= qx_lo;
      lo_y_r  <= qy_lo;
      lo_z_r  <= qz_lo;
      lo_ok_r <= {qz_c > half_z_r, qy_c > half_y_r, qx_c > half_x_r};
    end else if (pend_r) begin
      if (sub_r) begin
        acc_s_r <= acc_s_r - {{2{rd_data_r[ENTRY_W-1]}}, rd_data_r[ENTRY_W-1 -: SUM_W]};
        acc_q_r <= acc_q_r - {2'b00, rd_data_r[CNT_W +: SQ_W]};
        acc_n_r <= acc_n_r - {2'b00, rd_data_r[CNT_W-1:0]};
      end else begin
        acc_s_r <= acc_s_r + {{2{rd_data_r[ENTRY_W-1]}}, rd_data_r[ENTRY_W-1 -: SUM_W]};
        acc_q_r <= acc_q_r + {2'b00, rd_data_r[CNT_W +: SQ_W]};
        acc_n_r <= acc_n_r + {2'b00, rd_data_r[CNT_W-1:0]};
      end
    end
    sub_r <= rd_sub;

    case (state_r)
      ST_PREP: begin
        as_r    <= acc_s_r[33] ? 31'(-acc_s_r) : acc_s_r[30:0];
        aq_r    <= acc_q_r[49] ? 48'd0 : acc_q_r[47:0];
        n16_r   <= acc_n_r[15:0];
        nm1_r   <= acc_n_r[15:0] - 16'd1;
        neg_r   <= acc_s_r[33];
        cnt_o_r <= (acc_n_r > 18'sd0) ? acc_n_r[15:0] : 16'd0;
        mv_r    <= acc_n_r > 18'sd0;
        sv_r    <= acc_n_r > 18'sd1;
        mean_r  <= '0;
        sigma_r <= '0;
      end
      ST_MUL1: begin
        p0_r <= {24'd0, n16_r} * {16'd0, aq_r[23:0]};
        sq_r <= {31'd0, as_r} * {31'd0, as_r};
      end
      ST_MUL2: begin
        p1_r <= {24'd0, n16_r} * {16'd0, aq_r[47:24]};
        d_r  <= d_prod[29:0];
      end
      ST_MUL3: na_r <= sum_a;
      ST_DIVM: begin
        // Variance numerator n*sum2 - sum^2, floored at zero, scaled by 2^16.
        vd_r <= (na_r >= {2'b00, sq_r}) ? {na_r - {2'b00, sq_r}, 16'd0} : 80'd0;
        if (dv_cnt_r == 6'd0) begin
          if (!neg_r) begin
            mean_r <= (dv_q_r > 48'h7FFFFF) ? 24'h7FFFFF : dv_q_r[23:0];
          end else begin
            mean_r <= (dv_q_r > 48'h800000) ? 24'h800000 : (~dv_q_r[23:0] + 24'd1);
          end
        end
      end
      ST_DIVV: begin
        if ((dv_cnt_r == 6'd0) && dv_ovf_r) begin
          sigma_r <= 24'hFFFFFF;
        end
      end
      ST_SQRT: begin
        if (sq_cnt_r == 5'd0) begin
          sigma_r <= sq_root_r;
        end
      end
      default: ;
    endcase

    // Restoring divider, one quotient bit per cycle.
    if (dv_start) begin
      dv_ovf_r <= dv_start_dvd[79:48] >= {2'b00, dv_start_den};
      dv_rem_r <= dv_start_dvd[77:48];
      dv_dvd_r <= dv_start_dvd[47:0];
      dv_q_r   <= '0;
      dv_den_r <= dv_start_den;
    end else if (dv_cnt_r != 6'd0) begin
      if (dv_t >= {1'b0, dv_den_r}) begin
        dv_rem_r <= 30'(dv_t - {1'b0, dv_den_r});
        dv_q_r   <= {dv_q_r[46:0], 1'b1};
      end else begin
        dv_rem_r <= dv_t[29:0];
        dv_q_r   <= {dv_q_r[46:0], 1'b0};
      end
      dv_dvd_r <= {dv_dvd_r[46:0], 1'b0};
    end

    // Floor square root, one result bit per cycle.
    if (sq_start) begin
      sq_v_r    <= dv_q_r;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (sq_cnt_r != 5'd0) begin
      if (sq_r2 >= sq_tr) begin
        sq_rem_r  <= sq_r2 - sq_tr;
        sq_root_r <= {sq_root_r[22:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_r2;
        sq_root_r <= {sq_root_r[22:0], 1'b0};
      end
      sq_v_r <= {sq_v_r[45:0], 2'b00};
    end

    if ((state_r == ST_OUT) && (!out_valid_r || out_ready)) begin
      out_data_r.count       <= cnt_o_r;
      out_data_r.mean        <= mean_r;
      out_data_r.sigma       <= sigma_r;
      out_data_r.mean_valid  <= mv_r;
      out_data_r.sigma_valid <= sv_r;
    end
  end

  // ---------------- Assertions ----------------
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result appeared without the output state");

  a_sigma_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.sigma_valid) |->
      (out_data_r.mean_valid && (out_data_r.count > 16'd1)))
    else $error("sigma flagged valid with fewer than two samples");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_cnt_r != 6'd0) |-> ((state_r == ST_LDV1) || (state_r == ST_LDV2) ||
                            (state_r == ST_DIVM) || (state_r == ST_DIVV)))
    else $error("divider running outside a divide state");

  a_load_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && !stale_r) |->
      (({1'b0, ld_x_r} < sx_e) && ({1'b0, ld_y_r} < sy_e) && ({1'b0, ld_z_r} < sz_e)))
    else $error("load position outside the volume");

endmodule
`default_nettype wire

/* tb/sv/windowed_mean_sigma_box_filter_core_tb.sv */
// Self-checking testbench for windowed_mean_sigma_box_filter_core.
// Loads small volumes, queries windowed count / mean / sigma and checks each result
// against an in-bench predictor of the summed-area tables. Depends on wmsbf_pkg.
`timescale 1ns / 1ps
module windowed_mean_sigma_box_filter_core_tb;
  import wmsbf_pkg::*;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;
  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    idx;
    logic [15:0] val;
    logic [5:0]  qx;
    logic [5:0]  qy;
    logic [2:0]  qz;
    bit          typed;
    out_t        res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // Predictor state: tables indexed like the block, (z * 64 + y) * 64 + x.
  longint      sum_tab [DEPTH];
  longint      sq_tab  [DEPTH];
  int          cnt_tab [DEPTH];
  int unsigned load_pos;
  logic [6:0]  reg_sx, reg_sy;
  logic [3:0]  reg_sz;
  logic [5:0]  reg_hx, reg_hy;
  logic [2:0]  reg_hz;
  logic [15:0] reg_ignore;

  out_t        pending_results[$];
  int          mismatches;
  int          items_sent;
  bit          no_idle;
  int          hold_requests;

  windowed_mean_sigma_box_filter_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int eff(int v, int mx);
    if (v < 1) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic int tab_addr(int x, int y, int z);
    return (z * MAX_Y + y) * MAX_X + x;
  endfunction

  function automatic int unsigned volume_size();
    return eff(reg_sx, MAX_X) * eff(reg_sy, MAX_Y) * eff(reg_sz, MAX_Z);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Extends the three tables by one sample at the current raster position.
  function automatic void table_load(logic signed [15:0] smp);
    int sx, sy, sz, x, y, z, px, py, pz, dx, dy, dz, a;
    longint s, q;
    int n;
    int unsigned total;
    sx = eff(reg_sx, MAX_X);
    sy = eff(reg_sy, MAX_Y);
    sz = eff(reg_sz, MAX_Z);
    total = sx * sy * sz;
    if (load_pos >= total) load_pos = 0;
    x = load_pos % sx;
    y = (load_pos / sx) % sy;
    z = load_pos / (sx * sy);
    s = 0; q = 0; n = 0;
    if (smp != $signed(reg_ignore)) begin
      s = smp; q = longint'(smp) * smp; n = 1;
    end
    for (int c = 1; c < 8; c++) begin
      dx = c & 1; dy = (c >> 1) & 1; dz = (c >> 2) & 1;
      px = x - dx; py = y - dy; pz = z - dz;
      if (px >= 0 && py >= 0 && pz >= 0) begin
        a = tab_addr(px, py, pz);
        if (((dx + dy + dz) & 1) != 0) begin
          s += sum_tab[a]; q += sq_tab[a]; n += cnt_tab[a];
        end else begin
          s -= sum_tab[a]; q -= sq_tab[a]; n -= cnt_tab[a];
        end
      end
    end
    a = tab_addr(x, y, z);
    sum_tab[a] = s; sq_tab[a] = q; cnt_tab[a] = n;
    load_pos = (load_pos + 1 >= total) ? 0 : load_pos + 1;
  endfunction

  function automatic out_t window_stats(in_t it);
    int sx, sy, sz, x, y, z, hx, hy, hz, lx, ly, lz, px, py, pz, a;
    longint s, q, n, m;
    logic [63:0] as_, aq, d, quo, r;
    logic [127:0] pa, pb, diff, num;
    out_t o;
    sx = eff(reg_sx, MAX_X);
    sy = eff(reg_sy, MAX_Y);
    sz = eff(reg_sz, MAX_Z);
    x = (it.qx > sx - 1) ? sx - 1 : it.qx;
    y = (it.qy > sy - 1) ? sy - 1 : it.qy;
    z = (it.qz > sz - 1) ? sz - 1 : it.qz;
    hx = (x + reg_hx > sx - 1) ? sx - 1 : x + reg_hx;
    hy = (y + reg_hy > sy - 1) ? sy - 1 : y + reg_hy;
    hz = (z + reg_hz > sz - 1) ? sz - 1 : z + reg_hz;
    s = 0; q = 0; n = 0;
    for (int c = 0; c < 8; c++) begin
      lx = c & 1; ly = (c >> 1) & 1; lz = (c >> 2) & 1;
      px = lx ? x - reg_hx - 1 : hx;
      py = ly ? y - reg_hy - 1 : hy;
      pz = lz ? z - reg_hz - 1 : hz;
      if (px >= 0 && py >= 0 && pz >= 0) begin
        a = tab_addr(px, py, pz);
        if (((lx + ly + lz) & 1) != 0) begin
          s -= sum_tab[a]; q -= sq_tab[a]; n -= cnt_tab[a];
        end else begin
          s += sum_tab[a]; q += sq_tab[a]; n += cnt_tab[a];
        end
      end
    end
    o = '0;
    if (n > 0) begin
      m = (s * 256) / n;
      if (m > 8388607) m = 8388607;
      if (m < -8388608) m = -8388608;
      o.count = n[15:0];
      o.mean = m[23:0];
      o.mean_valid = 1'b1;
      if (n > 1) begin
        as_ = (s < 0) ? -s : s;
        aq = (q < 0) ? 0 : q;
        pa = 128'(n) * 128'(aq);
        pb = 128'(as_) * 128'(as_);
        diff = (pa < pb) ? 128'd0 : pa - pb;
        num = (diff[127:112] != 0) ? {128{1'b1}} : diff << 16;
        d = n * (n - 1);
        quo = (num[127:64] >= d) ? {64{1'b1}} : 64'(num / 128'(d));
        r = floor_sqrt(quo);
        o.sigma = (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
        o.sigma_valid = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin : receiver
    int stall_left;
    int hold_left;
    int holds_seen;
    if (hold_requests != holds_seen) begin
      holds_seen = hold_requests;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.count !== want.count || out_data.mean !== want.mean ||
            out_data.sigma !== want.sigma || out_data.mean_valid !== want.mean_valid ||
            out_data.sigma_valid !== want.sigma_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  task automatic send_item(in_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    items_sent++;
    if (it.func == FUNC_LOAD) table_load(it.sample);
    else pending_results.push_back(window_stats(it));
  endtask

  task automatic send_load(logic signed [15:0] smp);
    in_t it;
    it = '0;
    it.func = FUNC_LOAD;
    it.sample = smp;
    it.qx = $urandom; it.qy = $urandom; it.qz = $urandom;
    send_item(it);
  endtask

  task automatic send_query(logic [5:0] x, logic [5:0] y, logic [2:0] z);
    in_t it;
    it.func = FUNC_QUERY;
    it.sample = $urandom;
    it.qx = x; it.qy = y; it.qz = z;
    send_item(it);
  endtask

  // Stops offering items until every result is back and the core has settled.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SIZE_X: reg_sx = val[6:0];
      CFG_SIZE_Y: reg_sy = val[6:0];
      CFG_SIZE_Z: reg_sz = val[3:0];
      CFG_HALF_X: reg_hx = val[5:0];
      CFG_HALF_Y: reg_hy = val[5:0];
      CFG_HALF_Z: reg_hz = val[2:0];
      CFG_IGNORE: reg_ignore = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return reg_ignore;
    if (r < 16) return 16'sh7FFF;
    if (r < 22) return 16'sh8000;
    if (r < 55) return $urandom_range(0, 40) - 20;
    return $urandom;
  endfunction

  function automatic row_t cfg_row(cfg_idx_t idx, logic [15:0] val);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, val: val, qx: 0, qy: 0, qz: 0, typed: 0, res: '0};
    return r;
  endfunction

  function automatic row_t load_row(logic [15:0] smp);
    row_t r;
    r = '{kind: ROW_LOAD, idx: CFG_SIZE_X, val: smp, qx: 0, qy: 0, qz: 0, typed: 0,
          res: '0};
    return r;
  endfunction

  function automatic row_t query_row(logic [5:0] x, logic [5:0] y, logic [2:0] z,
                                     bit typed, out_t res);
    row_t r;
    r = '{kind: ROW_QUERY, idx: CFG_SIZE_X, val: 0, qx: x, qy: y, qz: z, typed: typed,
          res: res};
    return r;
  endfunction

  initial begin
    row_t        rows[$];
    out_t        full_one, empty_res, low_one, any_res;
    int          sizes[6][6];
    int          sx, sy, sz, old_total, phase, n_q;
    int unsigned prev_geom, geom;
    bit          filled;

    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    mismatches = 0;
    items_sent = 0;
    no_idle = 1'b0;
    hold_requests = 0;
    load_pos = 0;
    reg_sx = 64; reg_sy = 64; reg_sz = 8;
    reg_hx = 1; reg_hy = 1; reg_hz = 0;
    reg_ignore = 16'h8000;
    foreach (sum_tab[i]) begin
      sum_tab[i] = 0; sq_tab[i] = 0; cnt_tab[i] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    full_one = '{count: 16'd1, mean: 24'h7FFF00, sigma: 24'd0, mean_valid: 1'b1,
                 sigma_valid: 1'b0};
    empty_res = '0;
    low_one = '{count: 16'd1, mean: 24'h800000, sigma: 24'd0, mean_valid: 1'b1,
                sigma_valid: 1'b0};
    any_res = '0;

    // A single-voxel volume makes most answers obvious; the wider cases are predicted.
    rows.push_back(cfg_row(CFG_SIZE_X, 16'd1));
    rows.push_back(cfg_row(CFG_SIZE_Y, 16'd1));
    rows.push_back(cfg_row(CFG_SIZE_Z, 16'd1));
    rows.push_back(load_row(16'h7FFF));
    rows.push_back(query_row(6'd0, 6'd0, 3'd0, 1'b1, full_one));
    rows.push_back(query_row(6'd63, 6'd63, 3'd7, 1'b1, full_one));
    rows.push_back(load_row(16'h8000));
    rows.push_back(query_row(6'd0, 6'd0, 3'd0, 1'b1, empty_res));
    rows.push_back(cfg_row(CFG_IGNORE, 16'd0));
    rows.push_back(load_row(16'h8000));
    rows.push_back(query_row(6'd0, 6'd0, 3'd0, 1'b1, low_one));
    rows.push_back(cfg_row(CFG_SIZE_X, 16'd2));
    rows.push_back(load_row(16'h7FFF));
    rows.push_back(load_row(16'h8000));
    rows.push_back(query_row(6'd0, 6'd0, 3'd0, 1'b0, any_res));
    rows.push_back(cfg_row(CFG_HALF_X, 16'd0));
    rows.push_back(query_row(6'd1, 6'd0, 3'd0, 1'b0, any_res));
    rows.push_back(cfg_row(CFG_SIZE_X, 16'd0));
    rows.push_back(load_row(16'd5));
    rows.push_back(query_row(6'd9, 6'd0, 3'd0, 1'b0, any_res));

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG: begin
          wait_idle();
          write_reg(rows[i].idx, rows[i].val);
        end
        ROW_LOAD: send_load(rows[i].val);
        ROW_QUERY: begin
          send_query(rows[i].qx, rows[i].qy, rows[i].qz);
          // Typed rows replace the predicted entry with the value read off the spec.
          if (rows[i].typed) pending_results[$] = rows[i].res;
        end
        default: ;
      endcase
    end

    // Fixed phases first for the size and reach extremes, then random ones.
    sizes = '{'{64, 1, 1, 63, 0, 0}, '{1, 64, 1, 0, 63, 0}, '{2, 2, 8, 1, 1, 7},
              '{0, 0, 0, 5, 5, 5}, '{127, 3, 15, 2, 1, 3}, '{5, 5, 2, 0, 0, 0}};
    prev_geom = 0;
    phase = 0;
    filled = 1'b0;
    while (items_sent < 2000) begin
      wait_idle();
      if (phase < 6) begin
        sx = sizes[phase][0]; sy = sizes[phase][1]; sz = sizes[phase][2];
        write_reg(CFG_HALF_X, sizes[phase][3]);
        write_reg(CFG_HALF_Y, sizes[phase][4]);
        write_reg(CFG_HALF_Z, sizes[phase][5]);
      end else begin
        sx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) % 24 : $urandom_range(1, 8);
        sy = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) % 4 : $urandom_range(1, 3);
        if ($urandom_range(0, 1)) write_reg(CFG_HALF_X, $urandom_range(0, 3) == 0 ?
                                           $urandom_range(0, 63) : $urandom_range(0, 3));
        if ($urandom_range(0, 1)) write_reg(CFG_HALF_Y, $urandom_range(0, 3) == 0 ?
                                           $urandom_range(0, 63) : $urandom_range(0, 3));
        if ($urandom_range(0, 1)) write_reg(CFG_HALF_Z, $urandom_range(0, 7));
        if ($urandom_range(0, 2) == 0) write_reg(CFG_IGNORE, $urandom_range(0, 1) ?
                                                 16'($urandom) : 16'($urandom_range(0, 8) - 4));
      end
      write_reg(CFG_SIZE_X, sx);
      write_reg(CFG_SIZE_Y, sy);
      write_reg(CFG_SIZE_Z, sz);
      geom = (eff(reg_sx, MAX_X) << 16) | (eff(reg_sy, MAX_Y) << 4) | eff(reg_sz, MAX_Z);
      if (geom != prev_geom) filled = 1'b0;
      prev_geom = geom;
      no_idle = ($urandom_range(0, 4) == 0);

      // Every voxel of a new geometry is written before any query can see it. Loading
      // first runs on to the volume start, so that the full pass that follows only
      // builds on entries already rewritten in the new geometry.
      if (!filled) begin
        old_total = volume_size();
        if ((load_pos != 0) && (load_pos < old_total))
          repeat (old_total - load_pos) send_load(pick_sample());
        repeat (old_total) send_load(pick_sample());
        filled = 1'b1;
      end

      if (phase == 3) hold_requests++;
      n_q = $urandom_range(30, 60);
      for (int k = 0; k < n_q; k++) begin
        if ($urandom_range(0, 99) < 55) begin
          if ($urandom_range(0, 99) < 85)
            send_query($urandom_range(0, eff(reg_sx, MAX_X) - 1),
                       $urandom_range(0, eff(reg_sy, MAX_Y) - 1),
                       $urandom_range(0, eff(reg_sz, MAX_Z) - 1));
          else
            send_query($urandom, $urandom, $urandom);
        end else begin
          send_load(pick_sample());
        end
      end
      phase++;
    end

    wait_idle();
    repeat (200) @(negedge clk);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
